// ===== rtl/gvs_pkg.sv =====
// ----------------------------------------------------------------------------
// gvs_pkg
// Shared widths, constants, the exponent table and the structs that pass
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package gvs_pkg;

    localparam int COORD_W   = 16;
    localparam int SQ_W      = 32;
    localparam int SUM_W     = 48;
    localparam int GAIN_W    = 16;
    localparam int SIM_W     = 16;
    localparam int NUM_W     = GAIN_W + SUM_W;
    localparam int ACC_W     = 33;
    localparam int TAB_W     = 32;
    localparam int EXP_STEPS = 20;
    localparam int QUEUE_DEPTH_DEF  = 2;
    localparam int RESULT_DEPTH_DEF = 2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6554;
    localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};

    // round(2^32 * exp(-2^(k-16)))
    localparam logic [TAB_W-1:0] EXP_TAB [EXP_STEPS] = '{
        32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
        32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
        32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
        32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
        32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
    };

    typedef struct packed {
        logic [SUM_W-1:0] distance;
        logic [SUM_W-1:0] norm_a;
        logic [SUM_W-1:0] norm_b;
        logic             ovf;
    } t_vec_sums;

    typedef struct packed {
        logic [SIM_W-1:0] similarity;
        logic             degenerate;
        logic             saturated;
    } t_result;

endpackage

// ===== rtl/gvs_fifo.sv =====
// ----------------------------------------------------------------------------
// gvs_fifo
// Small register queue with push/full and pop/empty, head shown while not
// empty.
// ----------------------------------------------------------------------------
module gvs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/gvs_front.sv =====
// ----------------------------------------------------------------------------
// gvs_front
// Squares each coordinate pair, then adds the squares into three saturating
// sums; on the last pair the finished sums go to the queue.
// ----------------------------------------------------------------------------
module gvs_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [gvs_pkg::COORD_W-1:0]  i_coord_a,
    input  logic signed [gvs_pkg::COORD_W-1:0]  i_coord_b,
    input  logic                                i_last_element,
    output logic                                o_q_push,
    output gvs_pkg::t_vec_sums                  o_q_data,
    input  logic                                i_q_full
);

    import gvs_pkg::*;

    logic                       r_s1_valid;
    logic                       r_s1_last;
    logic [SQ_W-1:0]            r_sq_a;
    logic [SQ_W-1:0]            r_sq_b;
    logic [SQ_W-1:0]            r_sq_d;
    logic [SUM_W-1:0]           r_norm_a, r_norm_b, r_dist;
    logic                       r_ovf;

    logic                       advance;
    logic [COORD_W-1:0]         abs_a, abs_b, abs_d;
    logic signed [COORD_W:0]    diff;
    logic [SUM_W:0]             add_a, add_b, add_d;
    t_vec_sums                  sums;

    function automatic logic [COORD_W-1:0] abs16(input logic signed [COORD_W-1:0] v);
        abs16 = v[COORD_W-1] ? COORD_W'(-v) : v;
    endfunction

    assign advance = !(r_s1_valid && r_s1_last && i_q_full);
    assign full    = !advance;

    assign diff  = {i_coord_a[COORD_W-1], i_coord_a} - {i_coord_b[COORD_W-1], i_coord_b};
    assign abs_a = abs16(i_coord_a);
    assign abs_b = abs16(i_coord_b);
    assign abs_d = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];

    assign add_a = {1'b0, r_norm_a} + {{(SUM_W - SQ_W + 1){1'b0}}, r_sq_a};
    assign add_b = {1'b0, r_norm_b} + {{(SUM_W - SQ_W + 1){1'b0}}, r_sq_b};
    assign add_d = {1'b0, r_dist}   + {{(SUM_W - SQ_W + 1){1'b0}}, r_sq_d};

    always_comb begin
        sums.norm_a   = add_a[SUM_W] ? SUM_MAX : add_a[SUM_W-1:0];
        sums.norm_b   = add_b[SUM_W] ? SUM_MAX : add_b[SUM_W-1:0];
        sums.distance = add_d[SUM_W] ? SUM_MAX : add_d[SUM_W-1:0];
        sums.ovf      = r_ovf || add_a[SUM_W] || add_b[SUM_W] || add_d[SUM_W];
    end

    assign o_q_push = r_s1_valid && r_s1_last && advance;
    assign o_q_data = sums;

    // square stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && push) begin
            r_s1_last <= i_last_element;
            r_sq_a    <= SQ_W'(abs_a) * SQ_W'(abs_a);
            r_sq_b    <= SQ_W'(abs_b) * SQ_W'(abs_b);
            r_sq_d    <= SQ_W'(abs_d) * SQ_W'(abs_d);
        end
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_a <= '0;
            r_norm_b <= '0;
            r_dist   <= '0;
            r_ovf    <= 1'b0;
        end else if (r_s1_valid && advance) begin
            if (r_s1_last) begin
                r_norm_a <= '0;
                r_norm_b <= '0;
                r_dist   <= '0;
                r_ovf    <= 1'b0;
            end else begin
                r_norm_a <= sums.norm_a;
                r_norm_b <= sums.norm_b;
                r_dist   <= sums.distance;
                r_ovf    <= sums.ovf;
            end
        end
    end

endmodule

// ===== rtl/gvs_back.sv =====
// ----------------------------------------------------------------------------
// gvs_back
// Takes finished sums from the queue, forms gain*distance over two partial
// products, divides by the smaller norm one bit a cycle and evaluates the
// exponential with one table multiply a cycle.
// ----------------------------------------------------------------------------
module gvs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [gvs_pkg::GAIN_W-1:0]  i_gain,
    input  logic                        i_q_valid,
    input  gvs_pkg::t_vec_sums          i_q_data,
    output logic                        o_q_pop,
    output logic                        o_res_push,
    output gvs_pkg::t_result            o_res_data,
    input  logic                        i_res_full
);

    import gvs_pkg::*;

    localparam int HALF_W = SUM_W / 2;
    localparam int PP_W   = GAIN_W + HALF_W;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int K_W    = $clog2(EXP_STEPS);
    localparam int X_W    = EXP_STEPS;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL_LO = 7'b0000010,
        S_MUL_HI = 7'b0000100,
        S_SUM    = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_EXP    = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [SUM_W-1:0]   r_min;
    logic [SUM_W-1:0]   r_dist;
    logic               r_ovf;
    logic               r_deg;
    logic               r_big;
    logic [PP_W-1:0]    r_p_lo, r_p_hi;
    logic [NUM_W-1:0]   r_num;
    logic [SUM_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic [K_W-1:0]     r_k;
    logic [ACC_W-1:0]   r_acc;

    logic [SUM_W-1:0]   q_min;
    logic [SUM_W:0]     shifted;
    logic               qbit;
    logic [SUM_W:0]     rem_next;
    logic [NUM_W-1:0]   quo_next;
    logic [ACC_W+TAB_W:0] prod;
    logic [ACC_W:0]     rnd;
    logic [ACC_W-SIM_W:0] rnd_hi;

    assign q_min = (i_q_data.norm_a < i_q_data.norm_b) ? i_q_data.norm_a : i_q_data.norm_b;

    assign shifted  = {r_rem, r_num[NUM_W-1]};
    assign qbit     = (shifted >= {1'b0, r_min});
    assign rem_next = qbit ? shifted - {1'b0, r_min} : shifted;
    assign quo_next = {r_num[NUM_W-2:0], qbit};

    assign prod = (ACC_W + TAB_W + 1)'(r_acc) * (ACC_W + TAB_W + 1)'(EXP_TAB[r_k])
                + ((ACC_W + TAB_W + 1)'(1) << (TAB_W - 1));

    assign rnd    = {1'b0, r_acc} + ((ACC_W + 1)'(1) << (SIM_W - 1));
    assign rnd_hi = rnd[ACC_W:SIM_W];

    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_res_push = (r_state == S_DONE) && !i_res_full;

    always_comb begin
        o_res_data.saturated  = r_ovf;
        o_res_data.degenerate = r_deg;
        if (r_deg || r_big) begin
            o_res_data.similarity = '0;
        end else if (rnd_hi > (ACC_W - SIM_W + 1)'({SIM_W{1'b1}})) begin
            o_res_data.similarity = {SIM_W{1'b1}};
        end else begin
            o_res_data.similarity = rnd_hi[SIM_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = (q_min == '0) ? S_DONE : S_MUL_LO;
                end
            end
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_SUM;
            S_SUM:    n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_state = (|quo_next[NUM_W-1:X_W]) ? S_DONE : S_EXP;
                end
            end
            S_EXP: begin
                if (r_k == K_W'(EXP_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    r_min  <= q_min;
                    r_dist <= i_q_data.distance;
                    r_ovf  <= i_q_data.ovf;
                    r_deg  <= (q_min == '0);
                    r_big  <= 1'b0;
                end
            end
            S_MUL_LO: r_p_lo <= PP_W'(i_gain) * PP_W'(r_dist[HALF_W-1:0]);
            S_MUL_HI: r_p_hi <= PP_W'(i_gain) * PP_W'(r_dist[SUM_W-1:HALF_W]);
            S_SUM: begin
                r_num <= NUM_W'(r_p_lo) + (NUM_W'(r_p_hi) << HALF_W);
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_num <= quo_next;
                r_rem <= rem_next[SUM_W-1:0];
                r_cnt <= r_cnt + CNT_W'(1);
                r_acc <= ACC_W'(1) << TAB_W;
                r_k   <= '0;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_big <= |quo_next[NUM_W-1:X_W];
                end
            end
            S_EXP: begin
                if (r_num[r_k]) begin
                    r_acc <= prod[ACC_W+TAB_W-1:TAB_W];
                end
                r_k <= r_k + K_W'(1);
            end
            default: begin
            end
        endcase
    end

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_min))
        else $error("remainder not below divisor");

    a_exponent_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP) |-> (r_num[NUM_W-1:X_W] == '0))
        else $error("exponent out of table range");

    a_acc_at_most_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP) |-> (r_acc <= (ACC_W'(1) << TAB_W)))
        else $error("exponential accumulator above one");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res_data.degenerate) |-> (o_res_data.similarity == '0))
        else $error("degenerate result with nonzero similarity");

endmodule

// ===== rtl/gaussian_vector_similarity.sv =====
// ----------------------------------------------------------------------------
// gaussian_vector_similarity
// Streams coordinate pairs of two vectors and returns their Gaussian
// similarity in unsigned Q0.16 on each pair marked last.
//
//   channel   handshake             payload
//   input     push / full           i_coord_a, i_coord_b, i_last_element
//   result    pop / empty           o_similarity, o_degenerate, o_saturated
//   config    i_cfg_valid/o_cfg_ready  i_cfg_data (gain)
//
// one pair per cycle is taken while full is low; the squares are registered
// before the sums reach the queue; the back end takes one vector at a time:
// load, two partial products, sum, the bit-serial divide, the table multiplies
// and output; a zero smaller norm or a large exponent skips the multiplies
// full rises only while a finished vector waits for a free queue slot
// synchronous active-low reset clears all sums, queues and the sequencer
// ----------------------------------------------------------------------------
module gaussian_vector_similarity #(
    parameter int QUEUE_DEPTH  = gvs_pkg::QUEUE_DEPTH_DEF,
    parameter int RESULT_DEPTH = gvs_pkg::RESULT_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [gvs_pkg::COORD_W-1:0]  i_coord_a,
    input  logic signed [gvs_pkg::COORD_W-1:0]  i_coord_b,
    input  logic                                i_last_element,
    output logic                                empty,
    input  logic                                pop,
    output logic [gvs_pkg::SIM_W-1:0]           o_similarity,
    output logic                                o_degenerate,
    output logic                                o_saturated,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gvs_pkg::GAIN_W-1:0]          i_cfg_data
);

    import gvs_pkg::*;

    logic [GAIN_W-1:0] r_gain;
    logic              q_push, q_full, q_pop, q_empty;
    t_vec_sums         q_in, q_out;
    logic              res_push, res_full;
    t_result           res_in, res_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_gain <= i_cfg_data;
        end
    end

    gvs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_coord_a      (i_coord_a),
        .i_coord_b      (i_coord_b),
        .i_last_element (i_last_element),
        .o_q_push       (q_push),
        .o_q_data       (q_in),
        .i_q_full       (q_full)
    );

    gvs_fifo #(
        .WIDTH ($bits(t_vec_sums)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    gvs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_gain     (r_gain),
        .i_q_valid  (!q_empty),
        .i_q_data   (q_out),
        .o_q_pop    (q_pop),
        .o_res_push (res_push),
        .o_res_data (res_in),
        .i_res_full (res_full)
    );

    gvs_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RESULT_DEPTH)
    ) u_results (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_similarity = res_out.similarity;
    assign o_degenerate = res_out.degenerate;
    assign o_saturated  = res_out.saturated;

endmodule
